// ===== design/rlms_pkg.sv =====
`timescale 1ns / 1ps

package rlms_pkg;

  // Sample width is fixed by the frame format.
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned SCALED_W    = 16;

  // Sum of two squared samples.
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS + 1;
  // Mean square of the halved samples is at most 2^(2*SAMPLE_BITS-4).
  localparam int unsigned RAD_W  = 2 * SAMPLE_BITS - 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  // Partial remainder of the square root.
  localparam int unsigned SREM_W = ROOT_W + 2;
  // Multiplier width of the smoothing step: 65536 - w needs one bit more than w.
  localparam int unsigned MUL_W  = WEIGHT_W + 1;
  localparam int unsigned SACC_W = LEVEL_W + MUL_W + 1;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 16'd4588;
  localparam logic [LEVEL_W-1:0]  FULL_SCALE_RESET = 15'd5571;

  // Register index, taken from paddr[2].
  localparam logic REG_WEIGHT     = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  rms_level;
    logic [LEVEL_W-1:0]  smoothed_level;
    logic [SCALED_W-1:0] scaled_level;
    logic                frames_dropped;
  } out_word_t;

endpackage

// ===== design/rms_level_meter_smoothed.sv =====
// A frame without the last mark keeps the input stalled through the squaring and the
// accumulate step; a last frame then also runs the first division, the square root, the
// smoothing, rounding and the scaling division, and waits for a free output. The shared
// bit-serial divider is run twice per block. Squaring is one bit per cycle.
// Reset: asynchronous, active low; clears the block sums, the smoothed level and
// restores the configuration registers to their defaults.
`timescale 1ns / 1ps

module rms_level_meter_smoothed #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rlms_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rlms_pkg::out_word_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlms_pkg::APB_AW-1:0]       paddr,
  input  logic [rlms_pkg::APB_DW-1:0]       pwdata,
  output logic [rlms_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SUM_W = 2 * rlms_pkg::SAMPLE_BITS - 2 + $clog2(MAX_FRAMES);
  localparam int unsigned LVL_SHIFT_W = rlms_pkg::LEVEL_W + 16;
  localparam int unsigned DIV_W = (SUM_W > LVL_SHIFT_W) ? SUM_W : LVL_SHIFT_W;
  localparam int unsigned DVS_W = (CNT_W + 1 > rlms_pkg::LEVEL_W) ? CNT_W + 1
                                                                  : rlms_pkg::LEVEL_W;
  localparam int unsigned REM_W  = DVS_W + 1;
  localparam int unsigned STEP_W = $clog2(DIV_W);
  localparam int unsigned SB     = rlms_pkg::SAMPLE_BITS;
  localparam int unsigned LW     = rlms_pkg::LEVEL_W;
  localparam int unsigned RW     = rlms_pkg::ROOT_W;
  localparam int unsigned MW     = rlms_pkg::MUL_W;
  localparam int unsigned AW     = rlms_pkg::SACC_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SQR    = 9'b000000010,
    S_ACC    = 9'b000000100,
    S_DIV1   = 9'b000001000,
    S_SQRT   = 9'b000010000,
    S_SMOOTH = 9'b000100000,
    S_ROUND  = 9'b001000000,
    S_DIV2   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [rlms_pkg::WEIGHT_W-1:0] weight_q;
  logic [LW-1:0]                 full_scale_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic [LW-1:0]    level_q, level_d;
  logic             drop_q, drop_d;

  logic [SB-1:0]               mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic [SB-1:0]               sh_l_q, sh_l_d, sh_r_q, sh_r_d;
  logic [rlms_pkg::SQ_W-1:0]   prod_q, prod_d;
  logic                        last_q, last_d;
  logic                        take_q, take_d;

  logic [DIV_W-1:0] dq_q, dq_d;
  logic [REM_W-1:0] drem_q, drem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  logic [rlms_pkg::SREM_W-1:0] srem_q, srem_d;
  logic [RW-1:0]               root_q, root_d;

  logic [MW-1:0] ma_q, ma_d, mb_q, mb_d;
  logic [AW-1:0] sacc_q, sacc_d;

  logic                 out_valid_q, out_valid_d;
  rlms_pkg::out_word_t  out_q, out_d;

  // Combinational helpers.
  logic             in_accept, out_free;
  logic [SB-1:0]    left_u, right_u;
  logic [SUM_W-1:0] sum_n;
  logic [CNT_W-1:0] count_n;
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  logic [DIV_W-1:0] div_step_q;
  logic [REM_W-1:0] div_step_rem;
  logic [rlms_pkg::SREM_W-1:0] sq_r4, sq_trial;
  logic [AW-1:0]    sacc_round;
  logic [LW-1:0]    level_new;
  logic [LW-1:0]    fs_eff;
  logic [rlms_pkg::SCALED_W-1:0] scaled;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == rlms_pkg::REG_FULL_SCALE) begin
      prdata = rlms_pkg::APB_DW'(full_scale_q);
    end else begin
      prdata = rlms_pkg::APB_DW'(weight_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q     <= rlms_pkg::WEIGHT_RESET;
      full_scale_q <= rlms_pkg::FULL_SCALE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rlms_pkg::REG_FULL_SCALE) begin
        full_scale_q <= pwdata[LW-1:0];
      end else begin
        weight_q <= pwdata[rlms_pkg::WEIGHT_W-1:0];
      end
    end
  end

  assign left_u  = in_data_i.left_sample;
  assign right_u = in_data_i.right_sample;

  assign sum_n   = take_q ? sum_q + SUM_W'(prod_q >> 2) : sum_q;
  assign count_n = take_q ? count_q + CNT_W'(1) : count_q;

  // One restoring division step.
  assign rem_sh = {drem_q[REM_W-2:0], dq_q[DIV_W-1]};
  assign rem_ge = (rem_sh >= REM_W'(dvs_q));
  assign div_step_rem = rem_ge ? rem_sh - REM_W'(dvs_q) : rem_sh;
  assign div_step_q   = {dq_q[DIV_W-2:0], rem_ge};

  // One square root step takes the next two radicand bits.
  assign sq_r4    = {srem_q[rlms_pkg::SREM_W-3:0], dq_q[rlms_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};

  assign sacc_round = sacc_q + AW'(32768);
  assign level_new  = sacc_round[16 +: LW];
  assign fs_eff     = (full_scale_q == '0) ? LW'(1) : full_scale_q;

  // Quotient bits above the 16 result bits mean the level reached full scale.
  assign scaled = (dq_q[DIV_W-1:rlms_pkg::SCALED_W] != '0) ? '1
                                                          : dq_q[rlms_pkg::SCALED_W-1:0];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q + STEP_W'(1);
    count_d     = count_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    level_d     = level_q;
    drop_d      = drop_q;
    mag_l_d     = mag_l_q;
    mag_r_d     = mag_r_q;
    sh_l_d      = sh_l_q;
    sh_r_d      = sh_r_q;
    prod_d      = prod_q;
    last_d      = last_q;
    take_d      = take_q;
    dq_d        = dq_q;
    drem_d      = drem_q;
    dvs_d       = dvs_q;
    srem_d      = srem_q;
    root_d      = root_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    sacc_d      = sacc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (in_accept) begin
          mag_l_d = left_u[SB-1] ? ~left_u + SB'(1) : left_u;
          mag_r_d = right_u[SB-1] ? ~right_u + SB'(1) : right_u;
          sh_l_d  = left_u[SB-1] ? ~left_u + SB'(1) : left_u;
          sh_r_d  = right_u[SB-1] ? ~right_u + SB'(1) : right_u;
          prod_d  = '0;
          last_d  = in_data_i.last_frame;
          take_d  = (count_q < CNT_W'(MAX_FRAMES));
          state_d = S_SQR;
        end
      end

      S_SQR: begin
        // Both squares accumulate together, most significant multiplier bit first.
        prod_d = (prod_q << 1)
               + (sh_l_q[SB-1] ? rlms_pkg::SQ_W'(mag_l_q) : '0)
               + (sh_r_q[SB-1] ? rlms_pkg::SQ_W'(mag_r_q) : '0);
        sh_l_d = sh_l_q << 1;
        sh_r_d = sh_r_q << 1;
        if (step_q == STEP_W'(SB - 1)) begin
          state_d = S_ACC;
        end
      end

      S_ACC: begin
        step_d = '0;
        if (last_q) begin
          dq_d    = DIV_W'(sum_n);
          drem_d  = '0;
          dvs_d   = DVS_W'({count_n, 1'b0});
          drop_d  = ovf_q || !take_q;
          sum_d   = '0;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = S_DIV1;
        end else begin
          sum_d   = sum_n;
          count_d = count_n;
          ovf_d   = ovf_q || !take_q;
          state_d = S_IDLE;
        end
      end

      S_DIV1: begin
        dq_d   = div_step_q;
        drem_d = div_step_rem;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          step_d  = '0;
          srem_d  = '0;
          root_d  = '0;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        dq_d = dq_q << 2;
        if (sq_r4 >= sq_trial) begin
          srem_d = sq_r4 - sq_trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          srem_d = sq_r4;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        if (step_q == STEP_W'(RW - 1)) begin
          step_d  = '0;
          ma_d    = MW'(1 << rlms_pkg::WEIGHT_W) - MW'(weight_q);
          mb_d    = MW'(weight_q);
          sacc_d  = '0;
          state_d = S_SMOOTH;
        end
      end

      S_SMOOTH: begin
        sacc_d = (sacc_q << 1)
               + (ma_q[MW-1] ? AW'(level_q) : '0)
               + (mb_q[MW-1] ? AW'(root_q) : '0);
        ma_d = ma_q << 1;
        mb_d = mb_q << 1;
        if (step_q == STEP_W'(MW - 1)) begin
          state_d = S_ROUND;
        end
      end

      S_ROUND: begin
        step_d  = '0;
        level_d = level_new;
        dq_d    = DIV_W'({level_new, 16'd0});
        drem_d  = '0;
        dvs_d   = DVS_W'(fs_eff);
        state_d = S_DIV2;
      end

      S_DIV2: begin
        dq_d   = div_step_q;
        drem_d = div_step_rem;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        step_d = '0;
        if (out_free) begin
          out_d.rms_level      = LW'(root_q);
          out_d.smoothed_level = level_q;
          out_d.scaled_level   = scaled;
          out_d.frames_dropped = drop_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q  <= drop_d;
    mag_l_q <= mag_l_d;
    mag_r_q <= mag_r_d;
    sh_l_q  <= sh_l_d;
    sh_r_q  <= sh_r_d;
    prod_q  <= prod_d;
    last_q  <= last_d;
    take_q  <= take_d;
    dq_q    <= dq_d;
    drem_q  <= drem_d;
    dvs_q   <= dvs_d;
    srem_q  <= srem_d;
    root_q  <= root_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    sacc_q  <= sacc_d;
    out_q   <= out_d;
  end

endmodule

// ===== design/rlms_checker.sv =====
`timescale 1ns / 1ps

module rlms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rlms_pkg::in_word_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rlms_pkg::out_word_t out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Every accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a word");

  // A word that does not end a block never raises a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.last_frame && !out_valid_o |=> !out_valid_o)
    else $error("result raised by a word without the last mark");

  // A result appears only at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while the block was idle");

endmodule

bind rms_level_meter_smoothed rlms_checker u_rlms_checker (.*);

// ===== tb/rms_level_meter_smoothed_tb.sv =====
`timescale 1ns / 1ps

module rms_level_meter_smoothed_tb;

  localparam int FRAME_LIMIT = 256;

  typedef struct {
    int                  reps;
    logic signed [15:0]  left;
    logic signed [15:0]  right;
    bit                  last;
    bit                  typed;
    rlms_pkg::out_word_t want;
  } stim_row_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  rlms_pkg::in_word_t          in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  rlms_pkg::out_word_t         out_data_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [rlms_pkg::APB_AW-1:0] paddr       = '0;
  logic [rlms_pkg::APB_DW-1:0] pwdata      = '0;
  logic [rlms_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // Predictor state and its copy of the registers.
  longint unsigned    acc_sq;
  int unsigned        acc_frames;
  bit                 acc_dropped;
  longint unsigned    level_now;
  logic [15:0]        cfg_weight;
  logic [14:0]        cfg_full_scale;

  rlms_pkg::out_word_t pending_levels[$];
  stim_row_t          stim_rows[$];
  int                 mismatch_count = 0;
  int                 send_idle_pct  = 0;
  int                 recv_idle_pct  = 0;
  logic               hold_start     = 1'b0;
  bit                 hold_taken     = 1'b0;
  int                 hold_left      = 0;

  rms_level_meter_smoothed #(
    .MAX_FRAMES (FRAME_LIMIT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Advances the predictor by one accepted frame; returns 1 when the frame closes a block.
  function automatic bit meter_step(input rlms_pkg::in_word_t w,
                                    output rlms_pkg::out_word_t res);
    longint signed   l;
    longint signed   r;
    longint unsigned sq;
    longint unsigned n;
    longint unsigned root;
    longint unsigned fs;
    longint unsigned scaled;
    l = $signed(w.left_sample);
    r = $signed(w.right_sample);
    res = '0;
    if (acc_frames < FRAME_LIMIT) begin
      sq = l * l + r * r;
      acc_sq += sq >> 2;
      acc_frames++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (!w.last_frame) return 1'b0;
    n = (acc_frames == 0) ? 1 : acc_frames;
    root = int_sqrt(acc_sq / (2 * n));
    level_now = (level_now * (64'd65536 - cfg_weight) + root * cfg_weight + 64'd32768) >> 16;
    fs = (cfg_full_scale == 0) ? 1 : cfg_full_scale;
    scaled = (level_now << 16) / fs;
    if (scaled > 65535) scaled = 65535;
    res.rms_level      = root[14:0];
    res.smoothed_level = level_now[14:0];
    res.scaled_level   = scaled[15:0];
    res.frames_dropped = acc_dropped;
    acc_sq      = 0;
    acc_frames  = 0;
    acc_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic apb_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rlms_pkg::REG_WEIGHT) cfg_weight = val[15:0];
    else cfg_full_scale = val[14:0];
  endtask

  task automatic apb_read_check(logic idx);
    logic [31:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    want = (idx == rlms_pkg::REG_WEIGHT) ? {16'd0, cfg_weight} : {17'd0, cfg_full_scale};
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one word and waits for it to be taken; a typed row overrides the prediction.
  task automatic send_frame(rlms_pkg::in_word_t w, bit typed, rlms_pkg::out_word_t want);
    rlms_pkg::out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (meter_step(w, pred)) pending_levels.insert(pending_levels.size(), typed ? want : pred);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return $signed(16'($urandom_range(32)) - 16'd16);
      default: return $signed(16'($urandom_range(65535)));
    endcase
  endfunction

  task automatic send_block(int len);
    rlms_pkg::in_word_t w;
    for (int k = 0; k < len; k++) begin
      w.left_sample  = rand_sample();
      w.right_sample = rand_sample();
      w.last_frame   = (k == len - 1);
      send_frame(w, 1'b0, '0);
    end
  endtask

  function automatic void add_row(int reps, int l, int r, bit last, bit typed, bit dropped);
    stim_row_t row;
    row.reps  = reps;
    row.left  = 16'(l);
    row.right = 16'(r);
    row.last  = last;
    row.typed = typed;
    row.want  = '0;
    row.want.frames_dropped = dropped;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic settle();
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Receiver: checks each delivered word and decides the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing pending, rms", out_data_o.rms_level, -1);
      end else begin
        if (out_data_o.rms_level !== pending_levels[0].rms_level)
          report_mismatch("rms_level", out_data_o.rms_level, pending_levels[0].rms_level);
        if (out_data_o.smoothed_level !== pending_levels[0].smoothed_level)
          report_mismatch("smoothed_level", out_data_o.smoothed_level,
                          pending_levels[0].smoothed_level);
        if (out_data_o.scaled_level !== pending_levels[0].scaled_level)
          report_mismatch("scaled_level", out_data_o.scaled_level,
                          pending_levels[0].scaled_level);
        if (out_data_o.frames_dropped !== pending_levels[0].frames_dropped)
          report_mismatch("frames_dropped", out_data_o.frames_dropped,
                          pending_levels[0].frames_dropped);
        pending_levels.delete(0);
      end
    end
    if (hold_start && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = 800;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    rlms_pkg::in_word_t w;
    int                 mode;
    acc_sq         = 0;
    acc_frames     = 0;
    acc_dropped    = 1'b0;
    level_now      = 0;
    cfg_weight     = rlms_pkg::WEIGHT_RESET;
    cfg_full_scale = rlms_pkg::FULL_SCALE_RESET;

    // Rows of zero samples come first, while the smoothed level is still zero.
    add_row(1, 0, 0, 1'b1, 1'b1, 1'b0);
    add_row(FRAME_LIMIT + 1, 0, 0, 1'b1, 1'b1, 1'b1);
    add_row(1, 32767, 32767, 1'b1, 1'b0, 1'b0);
    add_row(1, -32768, -32768, 1'b1, 1'b0, 1'b0);
    add_row(1, -32768, 32767, 1'b1, 1'b0, 1'b0);
    add_row(1, 32767, -32768, 1'b0, 1'b0, 1'b0);
    add_row(1, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(1, 1, -1, 1'b1, 1'b0, 1'b0);
    add_row(1, -1, -1, 1'b1, 1'b0, 1'b0);
    add_row(4, 21845, -21846, 1'b1, 1'b0, 1'b0);
    add_row(1, 0, -32768, 1'b1, 1'b0, 1'b0);
    add_row(FRAME_LIMIT, -32768, -32768, 1'b1, 1'b0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(rlms_pkg::REG_WEIGHT);
    apb_read_check(rlms_pkg::REG_FULL_SCALE);

    for (int phase = 0; phase < 6; phase++) begin
      mode = phase / 2;
      send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 59 : 0;
      recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 12 : 0;
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            apb_write(rlms_pkg::REG_WEIGHT, 32'd65535);
            apb_write(rlms_pkg::REG_FULL_SCALE, 32'd32767);
          end
          2: begin
            apb_write(rlms_pkg::REG_WEIGHT, 32'd0);
            apb_write(rlms_pkg::REG_FULL_SCALE, 32'd1);
          end
          3: begin
            apb_write(rlms_pkg::REG_WEIGHT, 32'd32768);
            apb_write(rlms_pkg::REG_FULL_SCALE, 32'd0);
          end
          4: begin
            apb_write(rlms_pkg::REG_WEIGHT, $urandom_range(65535));
            apb_write(rlms_pkg::REG_FULL_SCALE, $urandom_range(1, 32767));
          end
          default: begin
            apb_write(rlms_pkg::REG_WEIGHT, 32'd1);
            apb_write(rlms_pkg::REG_FULL_SCALE, 32'd100);
          end
        endcase
        apb_read_check(rlms_pkg::REG_WEIGHT);
        apb_read_check(rlms_pkg::REG_FULL_SCALE);
      end
      if (phase == 0) begin
        foreach (stim_rows[i]) begin
          for (int k = 0; k < stim_rows[i].reps; k++) begin
            w.left_sample  = stim_rows[i].left;
            w.right_sample = stim_rows[i].right;
            w.last_frame   = (k == stim_rows[i].reps - 1) ? stim_rows[i].last : 1'b0;
            send_frame(w, stim_rows[i].typed && (k == stim_rows[i].reps - 1), stim_rows[i].want);
          end
        end
      end
      // Short blocks keep the output busy while the receiver holds off.
      if (phase == 3) hold_start <= 1'b1;
      if (phase == 1 || phase == 4) send_block($urandom_range(FRAME_LIMIT - 6, FRAME_LIMIT + 6));
      for (int count = 0; count < 45; ) begin
        int len;
        len = $urandom_range(1, 8);
        send_block(len);
        count += len;
      end
      in_valid_i <= 1'b0;
    end

    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
